// ===== design/csdcap_pkg.sv =====
// Package for the SD/MMC CSD capacity decoder.
// Holds field widths, stream packing widths and card kind codes.
// No dependencies.
`default_nettype none

package csdcap_pkg;

  // Input field widths.
  localparam int unsigned CsdHalfW = 64;
  localparam int unsigned AuCodeW  = 4;

  // Output field widths.
  localparam int unsigned SectorW   = 28;
  localparam int unsigned CapacityW = 37;
  localparam int unsigned EraseW    = 20;

  // Bytes per sector, as a shift.
  localparam int unsigned SectorShift = 9;

  // Stream data widths, padded to whole bytes.
  localparam int unsigned InDataW  = 136;
  localparam int unsigned OutDataW = 88;

  // Output field positions inside the result tdata.
  localparam int unsigned CapLsb   = SectorW;
  localparam int unsigned EraseLsb = SectorW + CapacityW;

  // Card kind register width and codes.
  localparam int unsigned KindW = 2;
  localparam logic [KindW-1:0] KindSdV2 = 2'd0;
  localparam logic [KindW-1:0] KindSdV1 = 2'd1;
  localparam logic [KindW-1:0] KindMmc  = 2'd2;

  // CSD structure code that selects the high capacity size rule.
  localparam logic [1:0] CsdStructV2 = 2'd1;

endpackage

`default_nettype wire

// ===== design/sd_csd_capacity_decoder_unit.sv =====
// An accepted input transaction passes the input register, then the result register.
// Throughput: one transaction per cycle; the input register and the result register
// form a two-stage pipeline that only holds while the output side stalls.
// Reset: rst_ni clears both stage valid flags and sets the card kind register to SD v2.
// Decodes a CSD register into sector count, byte capacity and erase block size.
// Depends on csdcap_pkg.
`default_nettype none

module sd_csd_capacity_decoder_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Card kind configuration write.
  input  wire logic                                cfg_we_i,
  input  wire logic [csdcap_pkg::KindW-1:0]        cfg_wdata_i,
  // Input stream.
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata, low bit up: csd_high[63:0], csd_low[63:0], au_code[3:0], zero pad[3:0].
  input  wire logic [csdcap_pkg::InDataW-1:0]      s_axis_tdata,
  // Output stream.
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // tdata, low bit up: sector_count[27:0], capacity_bytes[36:0], erase_sectors[19:0],
  // zero pad[2:0].
  output logic [csdcap_pkg::OutDataW-1:0]          m_axis_tdata,
  // tuser: format_error.
  output logic                                     m_axis_tuser
);

  // Card kind register.
  logic [csdcap_pkg::KindW-1:0] kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= csdcap_pkg::KindSdV2;
    end else if (cfg_we_i) begin
      kind_q <= cfg_wdata_i;
    end
  end

  // Pipeline control: the output register loads when empty or when taken.
  logic in_valid_q;
  logic out_valid_q;
  logic out_load;
  logic in_load;

  assign out_load      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_load;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Input register holds the accepted transaction.
  logic [csdcap_pkg::CsdHalfW-1:0] csd_high_q;
  logic [csdcap_pkg::CsdHalfW-1:0] csd_low_q;
  logic [csdcap_pkg::AuCodeW-1:0]  au_code_q;

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      csd_high_q <= s_axis_tdata[63:0];
      csd_low_q  <= s_axis_tdata[127:64];
      au_code_q  <= s_axis_tdata[131:128];
    end
  end

  // Split the CSD into bytes, byte 0 at the top of the high half.
  logic [7:0] csd_b [16];

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      csd_b[k]     = csd_high_q[63-8*k -: 8];
      csd_b[k + 8] = csd_low_q[63-8*k -: 8];
    end
  end

  // High capacity rule: 16-bit size field plus one, in units of 512 KiB.
  logic [15:0]                    v2_csize;
  logic [csdcap_pkg::SectorW-1:0] v2_sectors;

  assign v2_csize   = {csd_b[8], csd_b[9]} + 16'd1;
  assign v2_sectors = csdcap_pkg::SectorW'(v2_csize) << 10;

  // Standard capacity rule: block count shifted by read block length plus multiplier.
  logic [4:0]                     v1_exp;
  logic [12:0]                    v1_csize;
  logic [3:0]                     v1_shift;
  logic                           v1_size_err;
  logic [csdcap_pkg::SectorW-1:0] v1_sectors;

  assign v1_exp = 5'(csd_b[5][3:0]) + 5'(csd_b[10][7]) + {2'b00, csd_b[9][1:0], 1'b0} + 5'd2;
  assign v1_csize = 13'(csd_b[8][7:6]) + {3'b000, csd_b[7], 2'b00}
                  + {1'b0, csd_b[6][1:0], 10'd0} + 13'd1;
  assign v1_size_err = (v1_exp < 5'd9);
  assign v1_shift    = 4'(v1_exp - 5'd9);
  assign v1_sectors  = v1_size_err ? '0 : (csdcap_pkg::SectorW'(v1_csize) << v1_shift);

  // Select the size rule from the CSD structure field.
  logic                           use_v2;
  logic [csdcap_pkg::SectorW-1:0] sectors;
  logic                           size_err;

  assign use_v2   = (csd_b[0][7:6] == csdcap_pkg::CsdStructV2);
  assign sectors  = use_v2 ? v2_sectors : v1_sectors;
  assign size_err = !use_v2 && v1_size_err;

  // Erase block size for each card kind.
  logic [csdcap_pkg::EraseW-1:0] erase_sdv2;
  logic [7:0]                    sdv1_base;
  logic [1:0]                    sdv1_sh;
  logic [csdcap_pkg::EraseW-1:0] erase_sdv1;
  logic [5:0]                    mmc_grp;
  logic [5:0]                    mmc_mult;
  logic [11:0]                   mmc_prod;

  assign erase_sdv2 = csdcap_pkg::EraseW'(16) << au_code_q;
  assign sdv1_base  = {1'b0, csd_b[10][5:0], 1'b0} + 8'(csd_b[11][7]) + 8'd1;
  assign sdv1_sh    = csd_b[13][7:6];
  assign erase_sdv1 = (sdv1_sh == 2'd0) ? '0
                    : (csdcap_pkg::EraseW'(sdv1_base) << (sdv1_sh - 2'd1));
  assign mmc_grp    = 6'(csd_b[10][6:2]) + 6'd1;
  assign mmc_mult   = {1'b0, csd_b[10][1:0], csd_b[11][7:5]} + 6'd1;
  assign mmc_prod   = 12'(mmc_grp) * 12'(mmc_mult);

  logic [csdcap_pkg::EraseW-1:0] erase;
  logic                          erase_err;

  always_comb begin
    erase_err = 1'b0;
    case (kind_q)
      csdcap_pkg::KindSdV2: begin
        erase = erase_sdv2;
      end
      csdcap_pkg::KindSdV1: begin
        erase     = erase_sdv1;
        erase_err = (sdv1_sh == 2'd0);
      end
      default: begin
        // MMC rule; the unused code decodes the same way.
        erase = csdcap_pkg::EraseW'(mmc_prod);
      end
    endcase
  end

  // Result register.
  logic [csdcap_pkg::SectorW-1:0]   sectors_q;
  logic [csdcap_pkg::CapacityW-1:0] capacity_q;
  logic [csdcap_pkg::EraseW-1:0]    erase_q;
  logic                             err_q;

  always_ff @(posedge clk_i) begin
    if (out_load && in_valid_q) begin
      sectors_q  <= sectors;
      capacity_q <= {sectors, csdcap_pkg::SectorShift'(0)};
      erase_q    <= erase;
      err_q      <= size_err || erase_err;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, erase_q, capacity_q, sectors_q};
  assign m_axis_tuser  = err_q;

endmodule

`default_nettype wire

// ===== design/csdcap_checker.sv =====
// Port-level checker for the CSD capacity decoder, bound to the top level.
// Depends on csdcap_pkg and sd_csd_capacity_decoder_unit.
`default_nettype none

module csdcap_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                s_axis_tvalid,
  input wire logic                                s_axis_tready,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [csdcap_pkg::OutDataW-1:0]     m_axis_tdata,
  input wire logic                                m_axis_tuser
);

  // A stalled result transaction stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result transaction dropped while stalled");

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // Capacity is always the sector count times the sector size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[64:37] == m_axis_tdata[27:0]) && (m_axis_tdata[36:28] == 9'd0))
    else $error("capacity does not match sector count");

  // A flagged result with a nonzero size must come from a bad erase shift.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser && (m_axis_tdata[27:0] != 28'd0)
      |-> (m_axis_tdata[84:65] == 20'd0))
    else $error("format error without a zero size or erase value");

  // A new result must follow an input transaction through the input register and the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result appeared without a matching input transaction");

endmodule

bind sd_csd_capacity_decoder_unit csdcap_checker u_csdcap_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
